/* design/ptrk_pkg.sv */
`default_nettype none
package ptrk_pkg;

    // Axes that move, and the fixed number of axes carried on the ports
    localparam int AXES = 3;
    localparam int NAX  = 3;
    localparam int IW   = 2;

    // Working vector width for the norm limiter
    localparam int VW = 50;

    // Longest elapsed time taken as a valid step (0.2 s in Q16.16)
    localparam logic [31:0] DT_MAX = 32'd13107;

    // Stream word widths
    localparam int S_DATA_W = 248;
    localparam int M_DATA_W = 216;

    // Register indexes
    localparam logic [2:0] REG_MAX_SPEED = 3'd0;
    localparam logic [2:0] REG_MAX_ACCEL = 3'd1;
    localparam logic [2:0] REG_GAIN      = 3'd2;
    localparam logic [2:0] REG_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_DSTEP     = 3'd4;
    localparam logic [2:0] REG_START_X   = 3'd5;
    localparam logic [2:0] REG_START_Y   = 3'd6;
    localparam logic [2:0] REG_START_Z   = 3'd7;

    // Item kinds
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MOP_ACC,
        MOP_GAIN,
        MOP_SQ,
        MOP_SCALE,
        MOP_VDT
    } t_mop;

    // Norm limit source
    typedef enum logic {
        LIM_SPEED,
        LIM_ACCEL
    } t_lsrc;

    typedef struct packed {
        logic          take;
        logic          set_fresh;
        logic          clr_v;
        logic          mop_en;
        t_mop          mop;
        logic [IW-1:0] idx;
        logic          ld_alim;
        logic          ld_d;
        logic          ld_lim;
        t_lsrc         lsrc;
        logic          mag;
        logic          shr;
        logic          acc_sq;
        logic          rt_init;
        logic          rt_step;
        logic          div_init;
        logic          div_step;
        logic          ld_q;
        logic          form_dv;
        logic          form_nv;
        logic          ld_vel;
        logic          ld_pos;
        logic          ld_out;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic big;
        logic skip;
    } t_stat;

endpackage
`default_nettype wire

/* design/ptrk_dp.sv */
`default_nettype none
module ptrk_dp
    import ptrk_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_addr,
    input  wire logic [31:0]         i_cfg_wdata,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    input  wire logic                i_opcode,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    output logic [M_DATA_W-1:0]      o_m_tdata
);

    // Configuration
    logic [30:0]        r_max_speed, r_max_accel, r_gain;
    logic [31:0]        r_timeout;
    logic [13:0]        r_dstep;

    // Tracker state
    logic signed [31:0] r_pos  [NAX];
    logic signed [31:0] r_vel  [NAX];
    logic signed [31:0] r_tpos [NAX];
    logic signed [31:0] r_tvel [NAX];
    logic [19:0]        r_yaw_now, r_yaw_goal;
    logic [31:0]        r_age;
    logic               r_got, r_good, r_fresh;
    logic [13:0]        r_dt;

    // Scratch
    logic signed [VW-1:0] r_v [NAX];
    logic [VW-1:0]        r_a [NAX];
    logic                 r_shifted;
    logic [63:0]          r_sq, r_x, r_r, r_bit;
    logic [31:0]          r_rem;
    logic [30:0]          r_dsh, r_q, r_lim, r_alim;
    logic signed [32:0]   r_ma, r_mb;
    logic signed [65:0]   r_prod;
    logic [M_DATA_W-1:0]  r_out;

    // Input fields
    logic signed [31:0] in_goal [NAX];
    logic signed [31:0] in_feed [NAX];
    logic [19:0]        in_heading;
    logic               in_valid;
    logic [31:0]        in_elapsed;

    assign in_goal[0]  = i_s_tdata[31:0];
    assign in_goal[1]  = i_s_tdata[63:32];
    assign in_goal[2]  = i_s_tdata[95:64];
    assign in_feed[0]  = i_s_tdata[127:96];
    assign in_feed[1]  = i_s_tdata[159:128];
    assign in_feed[2]  = i_s_tdata[191:160];
    assign in_heading  = i_s_tdata[211:192];
    assign in_valid    = i_s_tdata[212];
    assign in_elapsed  = i_s_tdata[244:213];

    // Saturating age and step selection
    logic [32:0] age_sum;
    logic [31:0] age_next;
    logic [13:0] dt_next;
    logic        fresh_now;

    assign age_sum   = {1'b0, r_age} + {1'b0, in_elapsed};
    assign age_next  = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    assign dt_next   = (in_elapsed == 32'd0 || in_elapsed > DT_MAX) ? r_dstep : in_elapsed[13:0];
    assign fresh_now = r_got && (r_age <= r_timeout);

    // Status
    logic [31:0] nrm;
    logic        big;

    assign nrm = r_r[31:0];

    always_comb begin
        big = 1'b0;
        for (int k = 0; k < NAX; k++) begin
            if (r_a[k][VW-1:31] != '0) begin
                big = 1'b1;
            end
        end
    end

    assign o_stat.go   = fresh_now && r_good;
    assign o_stat.big  = big;
    assign o_stat.skip = (nrm == 32'd0) || (!r_shifted && nrm <= {1'b0, r_lim});

    // Multiplier operands
    logic signed [32:0] ma_next, mb_next;

    always_comb begin
        case (i_cmd.mop)
            MOP_ACC: begin
                ma_next = {2'b00, r_max_accel};
                mb_next = {19'd0, r_dt};
            end
            MOP_GAIN: begin
                ma_next = {2'b00, r_gain};
                mb_next = {r_tpos[i_cmd.idx][31], r_tpos[i_cmd.idx]}
                        - {r_pos[i_cmd.idx][31], r_pos[i_cmd.idx]};
            end
            MOP_SQ: begin
                ma_next = {2'b00, r_a[i_cmd.idx][30:0]};
                mb_next = {2'b00, r_a[i_cmd.idx][30:0]};
            end
            MOP_SCALE: begin
                ma_next = {2'b00, r_a[i_cmd.idx][30:0]};
                mb_next = {2'b00, r_lim};
            end
            MOP_VDT: begin
                ma_next = {r_vel[i_cmd.idx][31], r_vel[i_cmd.idx]};
                mb_next = {19'd0, r_dt};
            end
            default: begin
                ma_next = '0;
                mb_next = '0;
            end
        endcase
    end

    // Square root step
    logic [64:0] rt_sum;
    logic        rt_ge;

    assign rt_sum = {1'b0, r_r} + {1'b0, r_bit};
    assign rt_ge  = {1'b0, r_x} >= rt_sum;

    // Divider step
    logic [32:0] dv_t, dv_diff;
    logic        dv_ge;

    assign dv_t    = {r_rem, r_dsh[30]};
    assign dv_ge   = dv_t >= {1'b0, nrm};
    assign dv_diff = dv_t - {1'b0, nrm};

    // Position update with saturation
    logic signed [33:0] pos_sum;
    logic signed [31:0] pos_sat;

    assign pos_sum = {{2{r_pos[i_cmd.idx][31]}}, r_pos[i_cmd.idx]}
                   + {r_prod[48], r_prod[48:16]};

    always_comb begin
        if (pos_sum > 34'sd2147483647) begin
            pos_sat = 32'sh7FFF_FFFF;
        end else if (pos_sum < -34'sd2147483648) begin
            pos_sat = 32'sh8000_0000;
        end else begin
            pos_sat = pos_sum[31:0];
        end
    end

    // Signed quotient
    logic signed [VW-1:0] q_ext;

    assign q_ext = {{(VW-31){1'b0}}, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= 31'd98304;
            r_max_accel <= 31'd65536;
            r_gain      <= 31'd78643;
            r_timeout   <= 32'd65536;
            r_dstep     <= 14'd655;
            r_pos[0]    <= 32'sd0;
            r_pos[1]    <= 32'sd0;
            r_pos[2]    <= 32'sd65536;
            r_tpos[0]   <= 32'sd0;
            r_tpos[1]   <= 32'sd0;
            r_tpos[2]   <= 32'sd65536;
            for (int k = 0; k < NAX; k++) begin
                r_vel[k]  <= '0;
                r_tvel[k] <= '0;
            end
            r_yaw_now   <= '0;
            r_yaw_goal  <= '0;
            r_age       <= '0;
            r_got       <= 1'b0;
            r_good      <= 1'b1;
            r_fresh     <= 1'b0;
            r_dt        <= '0;
        end else begin
            // Register writes; a start position reloads position and target
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MAX_SPEED: r_max_speed <= i_cfg_wdata[30:0];
                    REG_MAX_ACCEL: r_max_accel <= i_cfg_wdata[30:0];
                    REG_GAIN:      r_gain      <= i_cfg_wdata[30:0];
                    REG_TIMEOUT:   r_timeout   <= i_cfg_wdata;
                    REG_DSTEP:     r_dstep     <= i_cfg_wdata[13:0];
                    REG_START_X: begin
                        r_pos[0]  <= i_cfg_wdata;
                        r_tpos[0] <= i_cfg_wdata;
                    end
                    REG_START_Y: begin
                        r_pos[1]  <= i_cfg_wdata;
                        r_tpos[1] <= i_cfg_wdata;
                    end
                    REG_START_Z: begin
                        r_pos[2]  <= i_cfg_wdata;
                        r_tpos[2] <= i_cfg_wdata;
                    end
                    default: ;
                endcase
            end

            // Take an item: a command restarts the age, a tick advances it
            if (i_cmd.take) begin
                if (i_opcode == OP_COMMAND) begin
                    r_got  <= 1'b1;
                    r_age  <= '0;
                    r_good <= in_valid;
                    if (in_valid) begin
                        for (int k = 0; k < NAX; k++) begin
                            r_tpos[k] <= in_goal[k];
                            r_tvel[k] <= in_feed[k];
                        end
                        r_yaw_goal <= in_heading;
                    end
                end else begin
                    r_age <= age_next;
                    r_dt  <= dt_next;
                end
            end

            if (i_cmd.set_fresh) begin
                r_fresh <= fresh_now;
            end

            if (i_cmd.ld_vel) begin
                for (int k = 0; k < NAX; k++) begin
                    if (k < AXES) begin
                        r_vel[k] <= r_v[k][31:0];
                    end
                end
                r_yaw_now <= r_yaw_goal;
            end

            if (i_cmd.ld_pos) begin
                r_pos[i_cmd.idx] <= pos_sat;
            end
        end
    end

    // Scratch datapath
    always_ff @(posedge i_clk) begin
        r_ma   <= i_cmd.mop_en ? ma_next : r_ma;
        r_mb   <= i_cmd.mop_en ? mb_next : r_mb;
        r_prod <= r_ma * r_mb;

        if (i_cmd.ld_alim) begin
            r_alim <= r_prod[46:16];
        end
        if (i_cmd.ld_lim) begin
            r_lim <= (i_cmd.lsrc == LIM_SPEED) ? r_max_speed : r_alim;
        end

        if (i_cmd.clr_v) begin
            for (int k = 0; k < NAX; k++) begin
                r_v[k] <= '0;
            end
        end
        if (i_cmd.ld_d) begin
            r_v[i_cmd.idx] <= r_prod[65:16]
                            + {{(VW-32){r_tvel[i_cmd.idx][31]}}, r_tvel[i_cmd.idx]};
        end
        if (i_cmd.form_dv || i_cmd.form_nv) begin
            for (int k = 0; k < NAX; k++) begin
                if (k < AXES) begin
                    r_v[k] <= i_cmd.form_dv
                        ? r_v[k] - {{(VW-32){r_vel[k][31]}}, r_vel[k]}
                        : r_v[k] + {{(VW-32){r_vel[k][31]}}, r_vel[k]};
                end
            end
        end
        if (i_cmd.ld_q) begin
            r_v[i_cmd.idx] <= r_v[i_cmd.idx][VW-1] ? -q_ext : q_ext;
        end

        // Magnitudes and prescale
        if (i_cmd.mag) begin
            for (int k = 0; k < NAX; k++) begin
                r_a[k] <= r_v[k][VW-1] ? -r_v[k] : r_v[k];
            end
            r_shifted <= 1'b0;
            r_sq      <= '0;
        end
        if (i_cmd.shr) begin
            for (int k = 0; k < NAX; k++) begin
                r_a[k] <= r_a[k] >> 1;
            end
            r_shifted <= 1'b1;
        end
        if (i_cmd.acc_sq) begin
            r_sq <= r_sq + r_prod[63:0];
        end

        // Bit-serial square root
        if (i_cmd.rt_init) begin
            r_x   <= r_sq;
            r_r   <= '0;
            r_bit <= 64'd1 << 62;
        end
        if (i_cmd.rt_step) begin
            if (rt_ge) begin
                r_x <= r_x - rt_sum[63:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end

        // Restoring divider, one quotient bit per cycle
        if (i_cmd.div_init) begin
            r_rem <= {1'b0, r_prod[61:31]};
            r_dsh <= r_prod[30:0];
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= dv_ge ? dv_diff[31:0] : dv_t[31:0];
            r_dsh <= r_dsh << 1;
            r_q   <= {r_q[29:0], dv_ge};
        end

        // Result word
        if (i_cmd.ld_out) begin
            r_out <= {1'b0, r_got, r_good, r_fresh, r_yaw_now,
                      r_vel[2], r_vel[1], r_vel[0], r_pos[2], r_pos[1], r_pos[0]};
        end
    end

    assign o_m_tdata = r_out;

endmodule
`default_nettype wire

/* design/ptrk_ctrl.sv */
`default_nettype none
module ptrk_ctrl
    import ptrk_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    input  wire logic  i_opcode,
    output logic       o_s_tready,
    input  wire logic  i_m_tready,
    output logic       o_m_tvalid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK,
        S_ACC_I, S_ACC_W, S_ACC_U,
        S_D_I, S_D_W, S_D_U,
        S_LMAG, S_LSHR,
        S_SQ_I, S_SQ_W, S_SQ_U,
        S_RT_INIT, S_RT, S_LCHK,
        S_SC_I, S_SC_W, S_SC_U, S_DIV, S_DIV_U,
        S_LDONE,
        S_P_I, S_P_W, S_P_U,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_D,
        PH_DV,
        PH_NV
    } t_phase;

    localparam logic [IW-1:0] LAST_IDX = IW'(AXES - 1);
    localparam logic [5:0]    RT_LAST  = 6'd31;
    localparam logic [5:0]    DIV_LAST = 6'd30;

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [IW-1:0] r_idx, n_idx;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_m_tvalid, n_m_tvalid;
    logic          accept, last;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign last       = (r_idx == LAST_IDX);
    assign o_m_tvalid = r_m_tvalid;

    // Sequence the tick computation
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.idx  = r_idx;
        o_cmd.mop  = MOP_ACC;
        o_cmd.lsrc = LIM_SPEED;

        case (r_state)
            S_IDLE: begin
                o_cmd.take = accept;
                if (accept && i_opcode == OP_TICK) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.set_fresh = 1'b1;
                o_cmd.clr_v     = 1'b1;
                n_state = i_stat.go ? S_ACC_I : S_OUT;
            end
            S_ACC_I: begin
                o_cmd.mop_en = 1'b1;
                o_cmd.mop    = MOP_ACC;
                n_state = S_ACC_W;
            end
            S_ACC_W: n_state = S_ACC_U;
            S_ACC_U: begin
                o_cmd.ld_alim = 1'b1;
                n_idx   = '0;
                n_state = S_D_I;
            end
            S_D_I: begin
                o_cmd.mop_en = 1'b1;
                o_cmd.mop    = MOP_GAIN;
                n_state = S_D_W;
            end
            S_D_W: n_state = S_D_U;
            S_D_U: begin
                o_cmd.ld_d = 1'b1;
                if (last) begin
                    o_cmd.ld_lim = 1'b1;
                    o_cmd.lsrc   = LIM_SPEED;
                    n_phase = PH_D;
                    n_state = S_LMAG;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_D_I;
                end
            end
            S_LMAG: begin
                o_cmd.mag = 1'b1;
                n_state = S_LSHR;
            end
            S_LSHR: begin
                if (i_stat.big) begin
                    o_cmd.shr = 1'b1;
                end else begin
                    n_idx   = '0;
                    n_state = S_SQ_I;
                end
            end
            S_SQ_I: begin
                o_cmd.mop_en = 1'b1;
                o_cmd.mop    = MOP_SQ;
                n_state = S_SQ_W;
            end
            S_SQ_W: n_state = S_SQ_U;
            S_SQ_U: begin
                o_cmd.acc_sq = 1'b1;
                if (last) begin
                    n_state = S_RT_INIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SQ_I;
                end
            end
            S_RT_INIT: begin
                o_cmd.rt_init = 1'b1;
                n_cnt   = '0;
                n_state = S_RT;
            end
            S_RT: begin
                o_cmd.rt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == RT_LAST) begin
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                n_idx   = '0;
                n_state = i_stat.skip ? S_LDONE : S_SC_I;
            end
            S_SC_I: begin
                o_cmd.mop_en = 1'b1;
                o_cmd.mop    = MOP_SCALE;
                n_state = S_SC_W;
            end
            S_SC_W: n_state = S_SC_U;
            S_SC_U: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DIV_U;
                end
            end
            S_DIV_U: begin
                o_cmd.ld_q = 1'b1;
                if (last) begin
                    n_state = S_LDONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SC_I;
                end
            end
            S_LDONE: begin
                case (r_phase)
                    PH_D: begin
                        o_cmd.form_dv = 1'b1;
                        o_cmd.ld_lim  = 1'b1;
                        o_cmd.lsrc    = LIM_ACCEL;
                        n_phase = PH_DV;
                        n_state = S_LMAG;
                    end
                    PH_DV: begin
                        o_cmd.form_nv = 1'b1;
                        o_cmd.ld_lim  = 1'b1;
                        o_cmd.lsrc    = LIM_SPEED;
                        n_phase = PH_NV;
                        n_state = S_LMAG;
                    end
                    default: begin
                        o_cmd.ld_vel = 1'b1;
                        n_idx   = '0;
                        n_state = S_P_I;
                    end
                endcase
            end
            S_P_I: begin
                o_cmd.mop_en = 1'b1;
                o_cmd.mop    = MOP_VDT;
                n_state = S_P_W;
            end
            S_P_W: n_state = S_P_U;
            S_P_U: begin
                o_cmd.ld_pos = 1'b1;
                if (last) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_P_I;
                end
            end
            S_OUT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    o_cmd.ld_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        if (o_cmd.ld_out) begin
            n_m_tvalid = 1'b1;
        end else if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end else begin
            n_m_tvalid = r_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_D;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_cnt      <= n_cnt;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // An accepted tick blocks intake until its word is loaded
    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_TICK) |=> !o_s_tready)
        else $error("intake open during tick");

    // Axis counter stays within the moving axes
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("axis index out of range");

    // A new result appears only from the output step
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_m_tvalid ##1 r_m_tvalid) |-> $past(r_state) == S_OUT)
        else $error("result valid without output step");

endmodule
`default_nettype wire

/* design/point_mass_position_tracker.sv */
//  channel | direction | handshake               | payload
//  s       | in        | i_s_tvalid / o_s_tready | i_s_tdata, i_s_tuser (opcode)
//  m       | out       | o_m_tvalid / i_m_tready | o_m_tdata
//  cfg     | in        | i_cfg_we                | i_cfg_addr, i_cfg_wdata
//
//  A command word is taken while idle and leaves intake open; a tick whose command
//  is stale or bad goes from the check step straight to the output step.
//  A steering tick runs three norm limits before its result is loaded, each with
//  a 32-step square root and, when it scales, a 31-step divider per axis, all
//  sharing one 33x33 multiplier.
//  Reset (synchronous, active low) loads the register defaults and start pose.
//  A waiting result blocks intake only while a later tick waits at its output step.
`default_nettype none
module point_mass_position_tracker
    import ptrk_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // goal_x, goal_y, goal_z, feed_vx, feed_vy, feed_vz, goal_heading,
    // goal_valid, elapsed, zero fill
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    // opcode
    input  wire logic                i_s_tuser,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading, fresh, command_ok,
    // ever_commanded, zero fill
    output logic [M_DATA_W-1:0]      o_m_tdata,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_addr,
    input  wire logic [31:0]         i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    ptrk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_opcode   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptrk_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_opcode    (i_s_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
`default_nettype wire
